[rtl/core/tckc_pkg.sv]
// Package for the typed composite key comparator.
// Holds type codes, verdict codes, register indexes and sizes.
// No dependencies.
`timescale 1ns / 1ps

package tckc_pkg;

	localparam int MAX_KEY_FIELDS = 8;
	localparam int POS_W = $clog2(MAX_KEY_FIELDS);

	// Type codes of the key schema.
	localparam logic [3:0] T_S8   = 4'd0;
	localparam logic [3:0] T_S16  = 4'd1;
	localparam logic [3:0] T_S32  = 4'd2;
	localparam logic [3:0] T_S64  = 4'd3;
	localparam logic [3:0] T_U8   = 4'd4;
	localparam logic [3:0] T_U16  = 4'd5;
	localparam logic [3:0] T_U32  = 4'd6;
	localparam logic [3:0] T_U64  = 4'd7;
	localparam logic [3:0] T_F32  = 4'd8;
	localparam logic [3:0] T_F64  = 4'd9;
	localparam logic [3:0] T_CHAR = 4'd10;
	localparam logic [3:0] T_BOOL = 4'd11;

	// Verdict codes, two bits signed.
	localparam logic [1:0] ORD_LT = 2'b11;
	localparam logic [1:0] ORD_EQ = 2'b00;
	localparam logic [1:0] ORD_GT = 2'b01;

	// Configuration register indexes.
	localparam logic REG_FIELD_COUNT = 1'b0;
	localparam logic REG_FIELD_TYPES = 1'b1;

endpackage

[rtl/core/typed_composite_key_compare_top.sv]
// Top level of the typed composite key comparator.
// Depends on tckc_pkg and tckc_field_cmp.
`timescale 1ns / 1ps

// Usage:
// Each input beat on the s_axis channel carries one field of both keys,
// field 0 first. The user must write the schema (field count, per-field
// type codes) on the cfg channel while the block is idle; the block does
// not enforce this. cfg_ready is always high. After the last field of a
// key pair, one beat on m_axis gives the order: -1 when the first key is
// smaller, 0 when equal, 1 when larger. The first differing field decides;
// later fields are taken but ignored. Throughput is one field beat per cycle
// unless a final field is blocked, set by the single compare stage. The
// last field passes one input register, then the compare feeding the
// result register. When the receiver stalls, the result register holds its
// beat and the input register keeps taking beats that produce no result; a
// final field waits in the input register until the result register frees
// up. Reset sets field count 1, all type codes 0, and clears the position,
// the held verdict and both valid flags.
module typed_composite_key_compare_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] first_value, [127:64] second_value
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata   // [1:0] order, [7:2] zero
);
	import tckc_pkg::*;

	logic [3:0]       count_q;
	logic [31:0]      types_q;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       count_eff;
	logic             in_last;
	logic             in_fire;

	logic             valid_s1;
	logic             last_s1;
	logic [3:0]       code_s1;
	logic [63:0]      a_s1;
	logic [63:0]      b_s1;

	logic             fixed_q;
	logic [1:0]       held_q;
	logic [1:0]       field_order;
	logic [1:0]       final_order;

	logic             out_valid_q;
	logic [1:0]       out_order_q;
	logic             out_free;
	logic             adv_s1;

	assign cfg_ready = 1'b1;

	// Count clamped to 1..MAX_KEY_FIELDS.
	always_comb begin
		if (count_q == 4'd0) begin
			count_eff = 4'd1;
		end else if (count_q > 4'(MAX_KEY_FIELDS)) begin
			count_eff = 4'(MAX_KEY_FIELDS);
		end else begin
			count_eff = count_q;
		end
	end

	assign in_last  = ({1'b0, pos_q} + 4'd1) >= count_eff;
	assign out_free = !out_valid_q || m_axis_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_fire  = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd1;
			types_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIELD_COUNT: count_q <= cfg_data[3:0];
				REG_FIELD_TYPES: types_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Field position advances per accepted beat, wraps after the last field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				pos_q <= in_last ? '0 : pos_q + 1'b1;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_s1 <= in_last;
			code_s1 <= types_q[{pos_q, 2'b00} +: 4];
			a_s1    <= s_axis_tdata[63:0];
			b_s1    <= s_axis_tdata[127:64];
		end
	end

	tckc_field_cmp u_cmp (
		.code  (code_s1),
		.a     (a_s1),
		.b     (b_s1),
		.order (field_order)
	);

	assign final_order = fixed_q ? held_q : field_order;

	// The verdict is fixed by the first differing field of the key pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= 1'b0;
			held_q  <= ORD_EQ;
		end else if (adv_s1) begin
			if (last_s1) begin
				fixed_q <= 1'b0;
				held_q  <= ORD_EQ;
			end else if (!fixed_q && field_order != ORD_EQ) begin
				fixed_q <= 1'b1;
				held_q  <= field_order;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_order_q <= final_order;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_order_q};

`ifndef SYNTHESIS
	a_order_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_order_q != 2'b10))
		else $error("result holds an illegal order code");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pos_q} < count_eff) || (count_q != $past(count_q)))
		else $error("field position passed the field count");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked final field");

	a_verdict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (!fixed_q && held_q == ORD_EQ))
		else $error("verdict not cleared after a key pair");
`endif

endmodule

[rtl/core/tckc_field_cmp.sv]
// Compares one key field of two keys under its type code.
// Depends on tckc_pkg.
`timescale 1ns / 1ps

module tckc_field_cmp (
	input  logic [3:0]  code,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [1:0]  order
);
	import tckc_pkg::*;

	logic [63:0] ka;
	logic [63:0] kb;
	logic        force_eq;

	always_comb begin
		ka = '0;
		kb = '0;
		force_eq = 1'b0;
		case (code)
			T_S8, T_CHAR: begin
				ka = {56'd0, a[7] ^ 1'b1, a[6:0]};
				kb = {56'd0, b[7] ^ 1'b1, b[6:0]};
			end
			T_S16: begin
				ka = {48'd0, ~a[15], a[14:0]};
				kb = {48'd0, ~b[15], b[14:0]};
			end
			T_S32: begin
				ka = {32'd0, ~a[31], a[30:0]};
				kb = {32'd0, ~b[31], b[30:0]};
			end
			T_S64: begin
				ka = {~a[63], a[62:0]};
				kb = {~b[63], b[62:0]};
			end
			T_U8: begin
				ka = {56'd0, a[7:0]};
				kb = {56'd0, b[7:0]};
			end
			T_U16: begin
				ka = {48'd0, a[15:0]};
				kb = {48'd0, b[15:0]};
			end
			T_U32: begin
				ka = {32'd0, a[31:0]};
				kb = {32'd0, b[31:0]};
			end
			T_U64: begin
				ka = a;
				kb = b;
			end
			T_F32: begin
				// Sign-magnitude mapped to an ordered unsigned key.
				ka = {32'd0, a[31] ? ~a[31:0] : {1'b1, a[30:0]}};
				kb = {32'd0, b[31] ? ~b[31:0] : {1'b1, b[30:0]}};
				force_eq = ((a[30:23] == 8'hFF) && (a[22:0] != '0))
					|| ((b[30:23] == 8'hFF) && (b[22:0] != '0))
					|| ((a[30:0] == '0) && (b[30:0] == '0));
			end
			T_F64: begin
				ka = a[63] ? ~a : {1'b1, a[62:0]};
				kb = b[63] ? ~b : {1'b1, b[62:0]};
				force_eq = ((a[62:52] == 11'h7FF) && (a[51:0] != '0))
					|| ((b[62:52] == 11'h7FF) && (b[51:0] != '0))
					|| ((a[62:0] == '0) && (b[62:0] == '0));
			end
			T_BOOL: begin
				ka = {63'd0, a[7:0] != 8'd0};
				kb = {63'd0, b[7:0] != 8'd0};
			end
			default: begin
				force_eq = 1'b1;
			end
		endcase
	end

	always_comb begin
		if (force_eq || ka == kb) begin
			order = ORD_EQ;
		end else if (ka < kb) begin
			order = ORD_LT;
		end else begin
			order = ORD_GT;
		end
	end

endmodule

[test/testbench.sv]
// Self-checking testbench for typed_composite_key_compare_top.
// Streams key pairs field by field under several schemas and checks each order beat
// against a bit-level predictor. Depends on tckc_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import tckc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // [63:0] first_value, [127:64] second_value
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [7:0]   m_axis_tdata;   // [1:0] order, [7:2] zero

	typed_composite_key_compare_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Field beats waiting to be driven, and orders waiting to come out.
	logic [127:0] field_q[$];
	logic [1:0]   order_q[$];
	int           errors;
	int           stall_cycles;
	bit           steady;      // no random idling while set
	bit           hold_req;    // asks the receiver for one long hold-off
	int           hold_left;

	// Shadow of the schema and of the compare state.
	logic [3:0]   sh_count;
	logic [31:0]  sh_types;
	int           sh_pos;
	bit           sh_fixed;
	logic [1:0]   sh_held;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [1:0] ucmp(logic [63:0] x, logic [63:0] y);
		if (x < y)
			return ORD_LT;
		else if (x > y)
			return ORD_GT;
		return ORD_EQ;
	endfunction

	// IEEE compare on raw bits: NaN on either side and a pair of zeros are equal.
	// Otherwise the sign-magnitude word is mapped to an order-preserving unsigned key.
	function automatic logic [1:0] float_order(logic [63:0] a, logic [63:0] b, bit wide);
		logic [63:0] xa, xb, sb, mask;
		bit          nan_a, nan_b;
		sb    = wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
		mask  = wide ? {64{1'b1}} : 64'hFFFF_FFFF;
		xa    = a & mask;
		xb    = b & mask;
		nan_a = wide ? (xa[62:52] == '1 && xa[51:0] != 0) : (xa[30:23] == '1 && xa[22:0] != 0);
		nan_b = wide ? (xb[62:52] == '1 && xb[51:0] != 0) : (xb[30:23] == '1 && xb[22:0] != 0);
		if (nan_a || nan_b)
			return ORD_EQ;
		if ((xa & ~sb) == 0 && (xb & ~sb) == 0)
			return ORD_EQ;
		xa = ((xa & sb) != 0) ? (~xa & mask) : (xa | sb);
		xb = ((xb & sb) != 0) ? (~xb & mask) : (xb | sb);
		return ucmp(xa, xb);
	endfunction

	function automatic logic [1:0] field_order(logic [3:0] code, logic [63:0] a, logic [63:0] b);
		case (code)
			T_S8, T_CHAR: return ucmp({56'b0, a[7:0] ^ 8'h80}, {56'b0, b[7:0] ^ 8'h80});
			T_S16: return ucmp({48'b0, a[15:0] ^ 16'h8000}, {48'b0, b[15:0] ^ 16'h8000});
			T_S32: return ucmp({32'b0, a[31:0] ^ 32'h8000_0000}, {32'b0, b[31:0] ^ 32'h8000_0000});
			T_S64: return ucmp({~a[63], a[62:0]}, {~b[63], b[62:0]});
			T_U8:  return ucmp({56'b0, a[7:0]}, {56'b0, b[7:0]});
			T_U16: return ucmp({48'b0, a[15:0]}, {48'b0, b[15:0]});
			T_U32: return ucmp({32'b0, a[31:0]}, {32'b0, b[31:0]});
			T_U64: return ucmp(a, b);
			T_F32: return float_order(a, b, 1'b0);
			T_F64: return float_order(a, b, 1'b1);
			T_BOOL: return ucmp({63'b0, |a[7:0]}, {63'b0, |b[7:0]});
			default: return ORD_EQ;
		endcase
	endfunction

	// Advances the shadow state by one accepted field beat.
	task automatic compare_field_beat(logic [127:0] beat);
		int         eff;
		logic [3:0] code;
		logic [1:0] r;
		eff = (sh_count == 0) ? 1 : (sh_count > MAX_KEY_FIELDS) ? MAX_KEY_FIELDS : sh_count;
		code = (sh_pos < 8) ? sh_types[4 * sh_pos +: 4] : 4'd0;
		if (!sh_fixed) begin
			r = field_order(code, beat[63:0], beat[127:64]);
			if (r != ORD_EQ) begin
				sh_fixed = 1'b1;
				sh_held  = r;
			end
		end
		if (sh_pos + 1 >= eff) begin
			order_q.push_back(sh_held);
			sh_pos   = 0;
			sh_fixed = 1'b0;
			sh_held  = ORD_EQ;
		end else begin
			sh_pos++;
		end
	endtask

	// Driver: one field beat per handshake, random gaps unless steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				compare_field_beat(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (field_q.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= field_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each order beat and applies back-pressure, including
	// one long hold-off on request so the input side fills and stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (order_q.size() == 0) begin
					$display("%0t: unexpected order beat, expected none, actual %h",
						$time, m_axis_tdata);
					errors++;
				end else if (m_axis_tdata !== {6'b0, order_q[0]}) begin
					$display("%0t: order mismatch, expected %h, actual %h",
						$time, {6'b0, order_q[0]}, m_axis_tdata);
					errors++;
					void'(order_q.pop_front());
				end else begin
					void'(order_q.pop_front());
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_left     <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 1) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				hold_left     <= 0;
				m_axis_tready <= steady || $urandom_range(99) >= 33;
			end
		end
	end

	// Watchdog on cycles with no handshake anywhere.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		if (idx == REG_FIELD_COUNT)
			sh_count = val[3:0];
		else
			sh_types = val;
		cfg_valid <= 1'b0;
	endtask

	// Sender pause: waits until every field went out and every order came back,
	// then lets the pipeline drain beats that carry no result. The check runs on
	// the falling edge so that the driver's updates of the same cycle are settled.
	task automatic drain;
		do
			@(negedge clk);
		while (field_q.size() != 0 || s_axis_tvalid || order_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(11))
			0: return 64'h0;
			1: return {64{1'b1}};
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h0000_0000_8000_0000;
			4: return 64'h7FC0_0001;                // single NaN
			5: return 64'h7FF8_0000_0000_0001;      // double NaN
			6: return 64'hFFFF_FFFF_FF80_0000;      // single -inf, junk above
			7: return 64'h7FF0_0000_0000_0000;      // double +inf
			8: return 64'h80;
			9: return $urandom_range(3);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [127:0] pick_pair();
		logic [63:0] a, b;
		a = pick_value();
		case ($urandom_range(3))
			0, 1: b = a;
			2: b = a + $urandom_range(2) - 1;
			default: b = pick_value();
		endcase
		return {b, a};
	endfunction

	function automatic logic [31:0] pick_types();
		logic [31:0] t;
		for (int i = 0; i < 8; i++)
			t[4 * i +: 4] = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 12))
				: 4'($urandom_range(11));
		return t;
	endfunction

	initial begin
		int          eff, sent;
		logic [3:0]  cnt;
		logic [63:0] zero_pairs[6];
		errors        = 0;
		stall_cycles  = 0;
		steady        = 0;
		hold_req      = 0;
		cfg_valid     = 0;
		cfg_index     = REG_FIELD_COUNT;
		cfg_data      = '0;
		sh_count      = 4'd1;
		sh_types      = '0;
		sh_pos        = 0;
		sh_fixed      = 0;
		sh_held       = ORD_EQ;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset schema first, then each type code alone on extremes,
		// signed zeros, NaN against numbers and nonzero booleans.
		field_q.push_back({64'h7F, 64'h80});
		field_q.push_back({64'hFF00, 64'h00FF});
		drain();
		zero_pairs = '{64'h0, 64'h8000_0000, 64'h8000_0000_0000_0000,
			64'h7FC0_0000, 64'h7FF8_0000_0000_0000, 64'h2};
		for (int c = 0; c < 16; c++) begin
			write_reg(REG_FIELD_TYPES, {8{4'(c)}});
			field_q.push_back({64'h0, {64{1'b1}}});
			field_q.push_back({zero_pairs[$urandom_range(5)], zero_pairs[$urandom_range(5)]});
			drain();
		end

		// Full-length keys where an early field decides and later ones differ.
		write_reg(REG_FIELD_COUNT, 4'd8);
		write_reg(REG_FIELD_TYPES, 32'hBA98_7654);
		for (int k = 0; k < 3; k++)
			for (int f = 0; f < 8; f++)
				field_q.push_back((f == k) ? {64'h1, 64'h2} : pick_pair());
		drain();

		// Random phases, one per schema; counts cover 0 and values past the maximum.
		sent = 0;
		for (int ph = 0; sent < 760; ph++) begin
			cnt = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : (ph == 2) ? 4'd1
				: 4'($urandom_range(15));
			write_reg(REG_FIELD_COUNT, cnt);
			write_reg(REG_FIELD_TYPES, (ph == 3) ? 32'hFFFF_FFFF : pick_types());
			eff = (cnt == 0) ? 1 : (cnt > MAX_KEY_FIELDS) ? MAX_KEY_FIELDS : cnt;
			steady   = (ph == 4);
			hold_req = (ph == 5);
			for (int k = 0; k < 80 / eff + 2; k++)
				for (int f = 0; f < eff; f++) begin
					field_q.push_back(pick_pair());
					sent++;
				end
			if (hold_req) begin
				repeat (2) @(posedge clk);
				hold_req = 0;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
